### sv/assert_macros.svh
// Assertion helpers for the RTL, used by ipd_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, masked while reset is low.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

### sv/ipd_pkg.sv
package ipd_pkg;

    localparam int DUR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int IDX_W       = 3;   // preamble count (up to 7) and bit index
    localparam int PULSE_CNT_W = 4;
    localparam int MAX_PULSES  = 16;

    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd475;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1253;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd391;
    localparam logic [DUR_W-1:0] RST_INTRO_MARK   = 16'd3510;
    localparam logic [DUR_W-1:0] RST_INTRO_SPACE  = 16'd1688;
    localparam logic [DUR_W-1:0] RST_BLOCK_GAP    = 16'd35440;
    localparam logic [DUR_W-1:0] RST_PREAMBLE_GAP = 16'd25000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_MARK     = 3'd0,
        REG_ONE_SPACE    = 3'd1,
        REG_ZERO_SPACE   = 3'd2,
        REG_INTRO_MARK   = 3'd3,
        REG_INTRO_SPACE  = 3'd4,
        REG_BLOCK_GAP    = 3'd5,
        REG_PREAMBLE_GAP = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        END_NONE,
        END_SEP,
        END_TAIL
    } end_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_ZERO,
        PH_PRE_GAP,
        PH_INTRO,
        PH_BITS,
        PH_END
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_start;
        logic       block_start;
        logic       block_end;
        logic       message_end;
        logic       checksum_slot;
    } in_item_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark_us;
        logic [DUR_W-1:0] space_us;
        logic [7:0]       byte_sent;
        logic             last_pulse;
    } out_item_t;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       message_start;
        logic       block_start;
        end_kind_t  end_kind;
    } desc_t;

endpackage

### sv/ir_pulse_distance_frame_encoder_top.sv
// On an idle block the first pulse of an item passes the item queue, the sequencer load and the
//   output register in that order; behind a busy sequencer it waits its turn.
// Throughput: one pulse per cycle unless out_ready stalls the output; an item has 8 to 16
//   pulses, sent by the single pulse sequencer, which moves to the next queued item with no gap.
// Input is taken while the two-entry item queue has room, so input and output stall independently.
// Reset (rst_n, asynchronous, active low): timing registers to their defaults, block sum to 0,
//   queue and output emptied.
module ir_pulse_distance_frame_encoder_top import ipd_pkg::*;
#(
    parameter int PREAMBLE_ZEROS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input items: one message byte plus framing flags
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    // result items: one infrared pulse each
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    // timing register writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data
);

    // Front -> queue
    logic  q_push;
    desc_t q_wdata;
    logic  q_full;

    // Queue -> back
    logic  q_pop;
    logic  q_valid;
    desc_t q_rdata;

    // Front: takes items, resolves the checksum slot against the running
    // block sum and works out which end pulse the item needs.
    ipd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Short queue decoupling the two halves.
    ipd_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    // Back: walks preamble, intro, eight bits LSB first and the end pulse,
    // one pulse per cycle unless the output stalls, into a registered output; caps an item at 16 pulses.
    ipd_back
    #(
        .PREAMBLE_ZEROS (PREAMBLE_ZEROS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

### sv/ipd_front.sv
module ipd_front import ipd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     q_push,
    output desc_t    q_wdata
);

    logic [7:0] block_sum_reg;
    logic [7:0] block_sum_next;
    logic [7:0] sum_base;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    // Block start clears the sum before it is used as checksum or summed.
    assign sum_base = in_item.block_start ? 8'd0 : block_sum_reg;

    always_comb
    begin
        q_wdata.byte_val      = in_item.checksum_slot ? sum_base : in_item.data_byte;
        q_wdata.message_start = in_item.message_start;
        q_wdata.block_start   = in_item.block_start;
        priority if (!in_item.block_end)
        begin
            q_wdata.end_kind = END_NONE;
        end
        else if (in_item.message_end)
        begin
            q_wdata.end_kind = END_TAIL;
        end
        else
        begin
            q_wdata.end_kind = END_SEP;
        end
    end

    always_comb
    begin
        block_sum_next = block_sum_reg;
        if (q_push)
        begin
            block_sum_next = in_item.checksum_slot ? sum_base
                                                   : sum_base + in_item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_sum_reg <= 8'd0;
        end
        else
        begin
            block_sum_reg <= block_sum_next;
        end
    end

endmodule

### sv/ipd_queue.sv
module ipd_queue import ipd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t wdata,
    output logic  full,
    input  logic  pop,
    output logic  rvalid,
    output desc_t rdata
);

    // Two-entry queue of classified items.
    desc_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full   = (count_reg == 2'd2);
    assign rvalid = (count_reg != 2'd0);
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/ipd_back.sv
`include "assert_macros.svh"

module ipd_back import ipd_pkg::*;
#(
    parameter int PREAMBLE_ZEROS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  desc_t                q_data,
    output logic                 q_pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item
);

    localparam logic [IDX_W-1:0]       PRE_LAST_IDX = IDX_W'(PREAMBLE_ZEROS - 1);
    localparam logic [IDX_W-1:0]       BIT_LAST_IDX = IDX_W'(7);
    localparam logic [PULSE_CNT_W-1:0] CNT_LAST     = PULSE_CNT_W'(MAX_PULSES - 1);

    logic [DUR_W-1:0] bit_mark_reg;
    logic [DUR_W-1:0] one_space_reg;
    logic [DUR_W-1:0] zero_space_reg;
    logic [DUR_W-1:0] intro_mark_reg;
    logic [DUR_W-1:0] intro_space_reg;
    logic [DUR_W-1:0] block_gap_reg;
    logic [DUR_W-1:0] preamble_gap_reg;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_t                 seq_next;
    phase_t                 first_phase;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic [PULSE_CNT_W-1:0] cnt_reg;
    logic [PULSE_CNT_W-1:0] cnt_next;
    desc_t                  cur_reg;
    desc_t                  cur_next;
    out_item_t              out_reg;
    out_item_t              out_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic      adv;
    logic      last_c;
    logic      load_new;
    out_item_t pulse_c;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_mark_reg     <= RST_BIT_MARK;
            one_space_reg    <= RST_ONE_SPACE;
            zero_space_reg   <= RST_ZERO_SPACE;
            intro_mark_reg   <= RST_INTRO_MARK;
            intro_space_reg  <= RST_INTRO_SPACE;
            block_gap_reg    <= RST_BLOCK_GAP;
            preamble_gap_reg <= RST_PREAMBLE_GAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIT_MARK:     bit_mark_reg     <= cfg_data;
                REG_ONE_SPACE:    one_space_reg    <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg   <= cfg_data;
                REG_INTRO_MARK:   intro_mark_reg   <= cfg_data;
                REG_INTRO_SPACE:  intro_space_reg  <= cfg_data;
                REG_BLOCK_GAP:    block_gap_reg    <= cfg_data;
                REG_PREAMBLE_GAP: preamble_gap_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign adv      = (phase_reg != PH_IDLE) && (!out_valid_reg || out_ready);
    assign last_c   = (seq_next == PH_IDLE) || (cnt_reg == CNT_LAST);
    assign load_new = q_valid && ((phase_reg == PH_IDLE) || (adv && last_c));
    assign q_pop    = load_new;

    always_comb
    begin
        priority if (q_data.message_start)
        begin
            first_phase = PH_PRE_ZERO;
        end
        else if (q_data.block_start)
        begin
            first_phase = PH_INTRO;
        end
        else
        begin
            first_phase = PH_BITS;
        end
    end

    // Next state: pulse sequence preamble -> intro -> bits -> end pulse
    always_comb
    begin
        unique case (phase_reg)
            PH_PRE_ZERO: seq_next = (idx_reg == PRE_LAST_IDX) ? PH_PRE_GAP : PH_PRE_ZERO;
            PH_PRE_GAP:  seq_next = cur_reg.block_start ? PH_INTRO : PH_BITS;
            PH_INTRO:    seq_next = PH_BITS;
            PH_BITS:
            begin
                if (idx_reg != BIT_LAST_IDX)
                begin
                    seq_next = PH_BITS;
                end
                else
                begin
                    seq_next = (cur_reg.end_kind == END_NONE) ? PH_IDLE : PH_END;
                end
            end
            PH_END:      seq_next = PH_IDLE;
            default:     seq_next = PH_IDLE;
        endcase

        priority if (load_new)
        begin
            phase_next = first_phase;
        end
        else if (adv)
        begin
            phase_next = last_c ? PH_IDLE : seq_next;
        end
        else
        begin
            phase_next = phase_reg;
        end

        // Index restarts on a new run, and also when the pulse cap cuts a run short
        priority if (load_new || (adv && (last_c || seq_next != phase_reg)))
        begin
            idx_next = '0;
        end
        else if (adv)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        priority if (load_new)
        begin
            cnt_next = '0;
        end
        else if (adv)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        cur_next = load_new ? q_data : cur_reg;
    end

    // Outputs: the pulse for the current step
    always_comb
    begin
        pulse_c.byte_sent  = cur_reg.byte_val;
        pulse_c.last_pulse = last_c;
        unique case (phase_reg)
            PH_PRE_ZERO:
            begin
                pulse_c.mark_us  = bit_mark_reg;
                pulse_c.space_us = zero_space_reg;
            end
            PH_PRE_GAP:
            begin
                pulse_c.mark_us  = bit_mark_reg;
                pulse_c.space_us = preamble_gap_reg;
            end
            PH_INTRO:
            begin
                pulse_c.mark_us  = intro_mark_reg;
                pulse_c.space_us = intro_space_reg;
            end
            PH_BITS:
            begin
                pulse_c.mark_us  = bit_mark_reg;
                pulse_c.space_us = cur_reg.byte_val[idx_reg] ? one_space_reg : zero_space_reg;
            end
            PH_END:
            begin
                pulse_c.mark_us  = bit_mark_reg;
                pulse_c.space_us = (cur_reg.end_kind == END_TAIL) ? '0 : block_gap_reg;
            end
            default:
            begin
                pulse_c.mark_us  = '0;
                pulse_c.space_us = '0;
            end
        endcase

        out_next       = adv ? pulse_c : out_reg;
        out_valid_next = adv ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `ASSERT_CLK(a_pre_idx_bound, (phase_reg == PH_PRE_ZERO) |-> (idx_reg <= PRE_LAST_IDX))
    `ASSERT_CLK(a_idx_zero_outside_runs, (phase_reg != PH_PRE_ZERO && phase_reg != PH_BITS) |-> (idx_reg == '0))
    `ASSERT_CLK(a_idle_drains, (phase_reg == PH_IDLE && out_ready) |=> !out_valid_reg)
    `ASSERT_CLK(a_cap_ends_item, (adv && cnt_reg == CNT_LAST) |=> (cnt_reg == '0))
    `ASSERT_NEVER(a_pop_while_busy, q_pop && phase_reg != PH_IDLE && !(adv && last_c))

endmodule
